[design/gray2_pixel_framebuffer_writer_core_defines.svh]
// ---------------------------------------------------------------------------
// gray2 frame store writer: assertion macros
// Concurrent check helpers, empty when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef GRAY2_PIXEL_FRAMEBUFFER_WRITER_CORE_DEFINES_SVH
`define GRAY2_PIXEL_FRAMEBUFFER_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define G2FBW_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define G2FBW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define G2FBW_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define G2FBW_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[design/g2fbw_pkg.sv]
// ---------------------------------------------------------------------------
// g2fbw_pkg
// Types and constants shared by the gray2 frame store writer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package g2fbw_pkg;

    localparam int CFG_W       = 10;
    localparam int ADDR_W      = 16;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    // reset values of the config registers
    localparam int PANEL_W_RST = 300;
    localparam int PANEL_H_RST = 400;

    // 5/6 bit to 8 bit expansion: (c*255 + rnd) / div by reciprocal
    localparam int CH_MAX      = 255;
    localparam int RND5        = 15;
    localparam int RND6        = 31;
    localparam int RECIP5      = 33826;   // ceil(2^20 / 31)
    localparam int SHIFT5      = 20;
    localparam int RECIP6      = 33289;   // ceil(2^21 / 63)
    localparam int SHIFT6      = 21;

    // luminance weights, scale 1000
    localparam int LUMA_R      = 299;
    localparam int LUMA_G      = 587;
    localparam int LUMA_B      = 114;
    localparam int LUMA_SCALE  = 1000;
    localparam int LUMA_RND    = LUMA_SCALE / 2;
    localparam int LUMA_SUM_W  = 18;

    // lum > t  <=>  weighted sum >= (t+1)*1000 - 500
    localparam int LVL_HI      = (191 + 1) * LUMA_SCALE - LUMA_RND;
    localparam int LVL_MID     = (127 + 1) * LUMA_SCALE - LUMA_RND;
    localparam int LVL_LO      = (63 + 1) * LUMA_SCALE - LUMA_RND;

    typedef enum logic [1:0] {
        GRAY_WHITE = 2'd0,
        GRAY_LIGHT = 2'd1,
        GRAY_DARK  = 2'd2,
        GRAY_BLACK = 2'd3
    } gray_t;

    typedef enum logic [2:0] {
        REG_PANEL_WIDTH  = 3'd0,
        REG_PANEL_HEIGHT = 3'd1,
        REG_GAP_X        = 3'd2,
        REG_GAP_Y        = 3'd3,
        REG_SWAP_XY      = 3'd4,
        REG_FLIP_X       = 3'd5,
        REG_FLIP_Y       = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_XFORM,
        ST_MULT,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] panel_width;
        logic [CFG_W-1:0] panel_height;
        logic [CFG_W-1:0] gap_x;
        logic [CFG_W-1:0] gap_y;
        logic             swap_xy;
        logic             flip_x;
        logic             flip_y;
    } cfg_t;

    // stage enables from the sequencer
    typedef struct packed {
        logic ld;
        logic st1;
        logic st2;
        logic st3;
    } stage_ctl_t;

    // address unit status back to the sequencer
    typedef struct packed {
        logic keep;
        logic idx_ok;
    } addr_stat_t;

endpackage

`default_nettype wire

[design/g2fbw_luma.sv]
// ---------------------------------------------------------------------------
// g2fbw_luma
// RGB565 to 2-bit gray code: channel expansion, weighted sum, threshold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module g2fbw_luma (
    input  wire logic                   aclk,
    input  wire g2fbw_pkg::stage_ctl_t  ctl,
    input  wire logic [15:0]            pixel_color,
    output g2fbw_pkg::gray_t            gray_code
);

    localparam int SW = g2fbw_pkg::LUMA_SUM_W;

    logic [4:0]  r5, b5;
    logic [5:0]  g6;
    logic [12:0] r_n, b_n;
    logic [13:0] g_n;
    logic [31:0] r_p, g_p, b_p;
    logic [7:0]  r8_reg, g8_reg, b8_reg;
    logic [SW-1:0] pr_reg, pg_reg, pb_reg;
    logic [SW-1:0] sum;
    g2fbw_pkg::gray_t gray_reg;
    g2fbw_pkg::gray_t gray_next;

    assign r5 = pixel_color[15:11];
    assign g6 = pixel_color[10:5];
    assign b5 = pixel_color[4:0];

    // c*255 + rnd, then divide by 31 or 63 through a reciprocal
    assign r_n = 13'(13'(r5) * 13'(g2fbw_pkg::CH_MAX) + 13'(g2fbw_pkg::RND5));
    assign b_n = 13'(13'(b5) * 13'(g2fbw_pkg::CH_MAX) + 13'(g2fbw_pkg::RND5));
    assign g_n = 14'(14'(g6) * 14'(g2fbw_pkg::CH_MAX) + 14'(g2fbw_pkg::RND6));
    assign r_p = 32'(r_n) * 32'(g2fbw_pkg::RECIP5);
    assign b_p = 32'(b_n) * 32'(g2fbw_pkg::RECIP5);
    assign g_p = 32'(g_n) * 32'(g2fbw_pkg::RECIP6);

    assign sum = pr_reg + pg_reg + pb_reg;

    always_comb begin
        priority if (sum >= SW'(g2fbw_pkg::LVL_HI)) begin
            gray_next = g2fbw_pkg::GRAY_WHITE;
        end else if (sum >= SW'(g2fbw_pkg::LVL_MID)) begin
            gray_next = g2fbw_pkg::GRAY_LIGHT;
        end else if (sum >= SW'(g2fbw_pkg::LVL_LO)) begin
            gray_next = g2fbw_pkg::GRAY_DARK;
        end else begin
            gray_next = g2fbw_pkg::GRAY_BLACK;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld) begin
            r8_reg <= 8'(r_p >> g2fbw_pkg::SHIFT5);
            g8_reg <= 8'(g_p >> g2fbw_pkg::SHIFT6);
            b8_reg <= 8'(b_p >> g2fbw_pkg::SHIFT5);
        end
        if (ctl.st1) begin
            pr_reg <= SW'(SW'(r8_reg) * SW'(g2fbw_pkg::LUMA_R));
            pg_reg <= SW'(SW'(g8_reg) * SW'(g2fbw_pkg::LUMA_G));
            pb_reg <= SW'(SW'(b8_reg) * SW'(g2fbw_pkg::LUMA_B));
        end
        if (ctl.st2) begin
            gray_reg <= gray_next;
        end
    end

    assign gray_code = gray_reg;

endmodule

`default_nettype wire

[design/g2fbw_addr.sv]
// ---------------------------------------------------------------------------
// g2fbw_addr
// Gap, panel clip, swap/mirror and byte address of the 2x2 packed store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module g2fbw_addr #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                          aclk,
    input  wire g2fbw_pkg::stage_ctl_t         ctl,
    input  wire g2fbw_pkg::cfg_t               cfg,
    input  wire logic signed [10:0]            pixel_x,
    input  wire logic signed [10:0]            pixel_y,
    output g2fbw_pkg::addr_stat_t              stat,
    output logic [g2fbw_pkg::ADDR_W-1:0]       rd_addr,
    output logic [g2fbw_pkg::ADDR_W-1:0]       byte_index,
    output logic                               sub_x,
    output logic                               sub_y
);

    localparam int XW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW  = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW  = g2fbw_pkg::CFG_W - 1;
    localparam int PW  = YW + HW;
    localparam int IW  = ((PW > XW) ? PW : XW) + 1;
    localparam int AW  = g2fbw_pkg::ADDR_W;
    localparam logic signed [11:0] LIM_X = 12'(MAX_WIDTH);
    localparam logic signed [11:0] LIM_Y = 12'(MAX_HEIGHT);

    logic signed [11:0] xg_reg, yg_reg;
    logic signed [11:0] pw_s, ph_s, w_s, h_s;
    logic signed [11:0] tx_pre, ty_pre, tx, ty;
    logic               on_panel, in_store;
    logic               keep_reg;
    logic [XW-1:0]      ux_reg;
    logic [YW-1:0]      uy_reg;
    logic [PW-1:0]      prod_reg;
    logic [IW-1:0]      idx_full;
    logic               idx_ok;
    logic [AW-1:0]      idx_reg;
    logic               subx_reg, suby_reg;

    assign pw_s = $signed(12'(cfg.panel_width));
    assign ph_s = $signed(12'(cfg.panel_height));

    assign on_panel = (xg_reg >= 12'sd0) && (xg_reg < pw_s) &&
                      (yg_reg >= 12'sd0) && (yg_reg < ph_s);

    assign w_s    = cfg.swap_xy ? ph_s : pw_s;
    assign h_s    = cfg.swap_xy ? pw_s : ph_s;
    assign tx_pre = cfg.swap_xy ? yg_reg : xg_reg;
    assign ty_pre = cfg.swap_xy ? xg_reg : yg_reg;
    assign tx     = cfg.flip_x ? (w_s - 12'sd1 - tx_pre) : tx_pre;
    assign ty     = cfg.flip_y ? (h_s - 12'sd1 - ty_pre) : ty_pre;

    // swap on a non-square panel can land outside the store
    assign in_store = (tx >= 12'sd0) && (ty >= 12'sd0) && (tx < pw_s) && (ty < ph_s) &&
                      (tx < LIM_X) && (ty < LIM_Y);

    assign idx_full = IW'(prod_reg) + IW'(ux_reg >> 1);
    assign idx_ok   = 32'(idx_full) < 32'(g2fbw_pkg::STORE_DEPTH);

    always_ff @(posedge aclk) begin
        if (ctl.ld) begin
            xg_reg <= 12'(pixel_x) + 12'($signed(cfg.gap_x));
            yg_reg <= 12'(pixel_y) + 12'($signed(cfg.gap_y));
        end
        if (ctl.st1) begin
            keep_reg <= on_panel && in_store;
            ux_reg   <= tx[XW-1:0];
            uy_reg   <= ty[YW-1:0];
        end
        if (ctl.st2) begin
            prod_reg <= PW'(PW'(uy_reg >> 1) * PW'(cfg.panel_width >> 1));
        end
        if (ctl.st3) begin
            idx_reg  <= AW'(idx_full);
            subx_reg <= ux_reg[0];
            suby_reg <= uy_reg[0];
        end
    end

    assign stat.keep   = keep_reg;
    assign stat.idx_ok = idx_ok;
    assign rd_addr     = AW'(idx_full);
    assign byte_index  = idx_reg;
    assign sub_x       = subx_reg;
    assign sub_y       = suby_reg;

endmodule

`default_nettype wire

[design/g2fbw_store.sv]
// ---------------------------------------------------------------------------
// g2fbw_store
// Packed frame store with one read and one write port, plus the byte merge.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module g2fbw_store (
    input  wire logic                          aclk,
    input  wire logic                          clr_en,
    input  wire logic [g2fbw_pkg::ADDR_W-1:0]  clr_addr,
    input  wire logic                          rd_en,
    input  wire logic [g2fbw_pkg::ADDR_W-1:0]  rd_addr,
    input  wire logic                          upd_en,
    input  wire logic [g2fbw_pkg::ADDR_W-1:0]  upd_addr,
    input  wire g2fbw_pkg::gray_t              gray_code,
    input  wire logic                          sub_x,
    input  wire logic                          sub_y,
    output logic [7:0]                         new_byte
);

    logic [7:0] mem [g2fbw_pkg::STORE_DEPTH];
    logic [7:0] rd_data_reg;
    logic [2:0] sh;
    logic [7:0] m_hi, m_lo;

    // pixel (x&1, y&1) owns bits 7-s and 5-s, s = 4*(x&1) + (y&1)
    assign sh   = {sub_x, 1'b0, sub_y};
    assign m_hi = 8'h80 >> sh;
    assign m_lo = 8'h20 >> sh;

    assign new_byte = (rd_data_reg & ~(m_hi | m_lo)) |
                      (gray_code[1] ? m_hi : 8'h00) |
                      (gray_code[0] ? m_lo : 8'h00);

    always_ff @(posedge aclk) begin
        if (clr_en) begin
            mem[clr_addr] <= 8'h00;
        end else if (upd_en) begin
            mem[upd_addr] <= new_byte;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/gray2_pixel_framebuffer_writer_core.sv]
// ---------------------------------------------------------------------------
// gray2_pixel_framebuffer_writer_core
// RGB565 pixels to a 2-bit gray, 2x2 packed frame store, one result per write.
// ---------------------------------------------------------------------------
//  port group   dir  contents
//  s_*          in   pixel beat: tdata = pixel_x, pixel_y, pixel_color
//  m_*          out  updated byte beat: tdata = byte_index, byte_value, gray_code
//  cfg_*        in   register write: cfg_index selects, cfg_data is the value
//
//  a pixel that is written goes through these steps from its accept to the next accept:
//  gap add, transform/weights, row multiply/threshold, store read, write back
//  a pixel dropped by the panel or store clip goes back to idle after the row multiply,
//  one whose byte index lies past the store after the store read step
//  after reset the store is zeroed, one byte a cycle, all 65536 bytes, with s_tready low
//  a stalled m_ side holds the write back cycle until the result register frees
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gray2_pixel_framebuffer_writer_core_defines.svh"

module gray2_pixel_framebuffer_writer_core #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,    // [10:0] pixel_x, [21:11] pixel_y, [37:22] pixel_color
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [15:0] byte_index, [23:16] byte_value, [25:24] gray_code
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

    localparam int AW = g2fbw_pkg::ADDR_W;

    g2fbw_pkg::state_t     state_reg, state_next;
    g2fbw_pkg::cfg_t       cfg_reg;
    g2fbw_pkg::stage_ctl_t ctl;
    g2fbw_pkg::addr_stat_t stat;
    g2fbw_pkg::gray_t      gray_code;

    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] rd_addr, byte_index;
    logic          sub_x, sub_y;
    logic          clr_en, rd_en, upd_en, out_load;
    logic [7:0]    new_byte;
    logic          m_tvalid_reg;
    logic [31:0]   m_tdata_reg;

    // ---------------- config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.panel_width  <= 10'(g2fbw_pkg::PANEL_W_RST);
            cfg_reg.panel_height <= 10'(g2fbw_pkg::PANEL_H_RST);
            cfg_reg.gap_x        <= '0;
            cfg_reg.gap_y        <= '0;
            cfg_reg.swap_xy      <= 1'b0;
            cfg_reg.flip_x       <= 1'b0;
            cfg_reg.flip_y       <= 1'b0;
        end else if (cfg_valid) begin
            unique case (g2fbw_pkg::cfg_idx_t'(cfg_index))
                g2fbw_pkg::REG_PANEL_WIDTH:  cfg_reg.panel_width  <= cfg_data;
                g2fbw_pkg::REG_PANEL_HEIGHT: cfg_reg.panel_height <= cfg_data;
                g2fbw_pkg::REG_GAP_X:        cfg_reg.gap_x        <= cfg_data;
                g2fbw_pkg::REG_GAP_Y:        cfg_reg.gap_y        <= cfg_data;
                g2fbw_pkg::REG_SWAP_XY:      cfg_reg.swap_xy      <= cfg_data[0];
                g2fbw_pkg::REG_FLIP_X:       cfg_reg.flip_x       <= cfg_data[0];
                g2fbw_pkg::REG_FLIP_Y:       cfg_reg.flip_y       <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= g2fbw_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clr_en) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        clr_en     = 1'b0;
        rd_en      = 1'b0;
        upd_en     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            g2fbw_pkg::ST_CLEAR: begin
                clr_en = 1'b1;
                if (clr_addr_reg == '1) begin
                    state_next = g2fbw_pkg::ST_IDLE;
                end
            end
            g2fbw_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.ld     = 1'b1;
                    state_next = g2fbw_pkg::ST_XFORM;
                end
            end
            g2fbw_pkg::ST_XFORM: begin
                ctl.st1    = 1'b1;
                state_next = g2fbw_pkg::ST_MULT;
            end
            g2fbw_pkg::ST_MULT: begin
                ctl.st2    = 1'b1;
                state_next = stat.keep ? g2fbw_pkg::ST_READ : g2fbw_pkg::ST_IDLE;
            end
            g2fbw_pkg::ST_READ: begin
                ctl.st3    = 1'b1;
                rd_en      = stat.idx_ok;
                state_next = stat.idx_ok ? g2fbw_pkg::ST_WRITE : g2fbw_pkg::ST_IDLE;
            end
            g2fbw_pkg::ST_WRITE: begin
                // write back only once the result register can take the beat
                if (!m_tvalid_reg || m_tready) begin
                    upd_en     = 1'b1;
                    out_load   = 1'b1;
                    state_next = g2fbw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = g2fbw_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- datapath
    g2fbw_luma u_luma (
        .aclk        (aclk),
        .ctl         (ctl),
        .pixel_color (s_tdata[37:22]),
        .gray_code   (gray_code)
    );

    g2fbw_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .aclk       (aclk),
        .ctl        (ctl),
        .cfg        (cfg_reg),
        .pixel_x    (s_tdata[10:0]),
        .pixel_y    (s_tdata[21:11]),
        .stat       (stat),
        .rd_addr    (rd_addr),
        .byte_index (byte_index),
        .sub_x      (sub_x),
        .sub_y      (sub_y)
    );

    g2fbw_store u_store (
        .aclk      (aclk),
        .clr_en    (clr_en),
        .clr_addr  (clr_addr_reg),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .upd_en    (upd_en),
        .upd_addr  (byte_index),
        .gray_code (gray_code),
        .sub_x     (sub_x),
        .sub_y     (sub_y),
        .new_byte  (new_byte)
    );

    // ---------------- result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'b000000, gray_code, new_byte, byte_index};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- checks
    `G2FBW_ASSERT_IMPLY(a_result_from_write, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == g2fbw_pkg::ST_WRITE)
    `G2FBW_ASSERT_NEXT(a_write_holds_on_stall, aclk, aresetn, state_reg == g2fbw_pkg::ST_WRITE && m_tvalid_reg && !m_tready, state_reg == g2fbw_pkg::ST_WRITE)
    `G2FBW_ASSERT_NEXT(a_clear_sweep_done, aclk, aresetn, state_reg == g2fbw_pkg::ST_CLEAR && clr_addr_reg == '1, state_reg == g2fbw_pkg::ST_IDLE && clr_addr_reg == '0)

endmodule

`default_nettype wire
